[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/e2c_pkg.sv]
package e2c_pkg;

  localparam int TZ_UNIT_SECONDS_DEF = 900;
  localparam int NSTAGE = 8;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;
  localparam int DAYS_PER_WEEK = 7;
  localparam int QUAD_DAYS     = 1461;
  localparam int BASE_YEAR     = 1970;
  // 1970-01-01 was a Thursday; weekday 0 is Monday
  localparam int WEEKDAY_BIAS  = 3;

  // Reciprocals for constant division: q = (x * RECIP) >> SH
  // Day split works on epoch >> 7 (86400 = 128 * 675); estimate may be one low.
  localparam logic [25:0] DAY_RECIP  = 26'd50903316;
  localparam int          DAY_SH     = 35;
  localparam logic [16:0] HOUR_RECIP = 17'd74566;
  localparam int          HOUR_SH    = 28;
  localparam logic [17:0] MIN_RECIP  = 18'd139811;
  localparam int          MIN_SH     = 23;
  localparam logic [16:0] WEEK_RECIP = 17'd74899;
  localparam int          WEEK_SH    = 19;
  localparam logic [15:0] QUAD_RECIP = 16'd45934;
  localparam int          QUAD_SH    = 26;

  typedef logic [15:0] days_t;
  typedef logic [16:0] clock_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  // First day-of-year of month idx (0 = January)
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] s;
    case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && idx >= 4'd2) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

[design/epoch_to_calendar_core.sv]
// Converts seconds since 1970-01-01 00:00:00 into year, month, day, hour,
// minute, second and weekday (0 = Monday). Each transaction first moves the
// epoch forward (kind 0) or back (kind 1) by day_offset whole days, then adds
// tz_offset_units * TZ_UNIT_SECONDS; all sums wrap modulo 2^32, and every
// fourth year is a leap year (2100 included). The datapath is an 8-stage
// pipeline of reciprocal multiplies standing in for the divisions: it takes
// one transaction per cycle while the output is not stalled, and each result
// is registered in every stage in turn before it is presented on the output.
// Bubbles in the pipeline close up under an output stall, so input keeps
// flowing until all 8 stages hold data. The time zone register is written
// through the cfg port (always ready) and should only change while the
// pipeline is empty.
`include "assert_macros.svh"

module epoch_to_calendar_core #(
  parameter int TZ_UNIT_SECONDS = e2c_pkg::TZ_UNIT_SECONDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [7:0] tz_offset_units,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       epoch_seconds,
  input  logic [7:0]        day_offset,
  input  logic              kind,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second,
  output logic [2:0]        weekday
);
  import e2c_pkg::*;

  logic signed [7:0] tz_units;
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  days_t       days;
  clock_t      clock;
  tod_t        tod;
  tod_t        tod_out;
  logic [5:0]  quad;
  logic [10:0] quad_day;

  logic        time_ok;
  logic        date_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz_units <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tz_units <= tz_offset_units;
    end
  end

  // a stage may load when empty or when the stage after it moves
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NSTAGE-1];

  e2c_front #(
    .TZ_UNIT_SECONDS(TZ_UNIT_SECONDS)
  ) u_front (
    .clk          (clk),
    .en           (en[3:0]),
    .epoch_seconds(epoch_seconds),
    .day_offset   (day_offset),
    .kind         (kind),
    .tz_units     (tz_units),
    .days         (days),
    .clock        (clock)
  );

  e2c_split u_split (
    .clk     (clk),
    .en      (en[5:4]),
    .days    (days),
    .clock   (clock),
    .tod     (tod),
    .quad    (quad),
    .quad_day(quad_day)
  );

  e2c_date u_date (
    .clk     (clk),
    .en      (en[7:6]),
    .tod     (tod),
    .quad    (quad),
    .quad_day(quad_day),
    .tod_out (tod_out),
    .year    (year),
    .month   (month),
    .day     (day)
  );

  assign hour    = tod_out.hour;
  assign minute  = tod_out.minute;
  assign second  = tod_out.second;
  assign weekday = tod_out.weekday;

  assign time_ok = hour < 5'd24 && minute < 6'd60 && second < 6'd60 && weekday < 3'd7;
  assign date_ok = month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 &&
                   year >= 12'(BASE_YEAR) && year <= 12'd2106;

  `ASSERT_IMP(a_stall_full, in_stall, &v)
  `ASSERT_NXT(a_accept_enters, in_valid && !in_stall, v[0])
  `ASSERT_IMP(a_time_range, out_valid, time_ok)
  `ASSERT_IMP(a_date_range, out_valid, date_ok)

endmodule

[design/e2c_front.sv]
module e2c_front #(
  parameter int TZ_UNIT_SECONDS = e2c_pkg::TZ_UNIT_SECONDS_DEF
) (
  input  logic                clk,
  input  logic [3:0]          en,
  input  logic [31:0]         epoch_seconds,
  input  logic [7:0]          day_offset,
  input  logic                kind,
  input  logic signed [7:0]   tz_units,
  output e2c_pkg::days_t      days,
  output e2c_pkg::clock_t     clock
);
  import e2c_pkg::*;

  localparam int TZ_W = $clog2(TZ_UNIT_SECONDS + 1);
  localparam int ZP_W = TZ_W + 9;
  localparam logic signed [TZ_W:0] TZ_K = (TZ_W + 1)'(TZ_UNIT_SECONDS);

  logic [24:0]            shift;
  logic signed [ZP_W-1:0] zone_prod;
  logic [31:0]            shift32;
  logic [31:0]            zone32;
  logic [31:0]            e_next;

  logic [31:0] e0;
  logic [50:0] p1;
  logic [31:0] e1;
  days_t       q2;
  logic [31:0] qm2;
  logic [31:0] e2;
  logic [17:0] rem;

  always_comb begin
    shift     = 25'(day_offset) * 25'(SECS_PER_DAY);
    shift32   = 32'(shift);
    zone_prod = tz_units * TZ_K;
    zone32    = 32'(zone_prod);
    if (kind) begin
      e_next = epoch_seconds - shift32 + zone32;
    end else begin
      e_next = epoch_seconds + shift32 + zone32;
    end
  end

  assign rem = 18'(e2 - qm2);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e0 <= e_next;
    end
    if (en[1]) begin
      p1 <= 51'(e0[31:7]) * 51'(DAY_RECIP);
      e1 <= e0;
    end
    if (en[2]) begin
      q2  <= days_t'(p1 >> DAY_SH);
      qm2 <= 32'(32'(days_t'(p1 >> DAY_SH)) * 32'(SECS_PER_DAY));
      e2  <= e1;
    end
    if (en[3]) begin
      // quotient estimate is exact or one short
      if (rem >= 18'(SECS_PER_DAY)) begin
        days  <= q2 + days_t'(1);
        clock <= clock_t'(rem - 18'(SECS_PER_DAY));
      end else begin
        days  <= q2;
        clock <= clock_t'(rem);
      end
    end
  end

endmodule

[design/e2c_split.sv]
module e2c_split (
  input  logic            clk,
  input  logic [1:0]      en,
  input  e2c_pkg::days_t  days,
  input  e2c_pkg::clock_t clock,
  output e2c_pkg::tod_t   tod,
  output logic [5:0]      quad,
  output logic [10:0]     quad_day
);
  import e2c_pkg::*;

  logic [33:0] hp;
  logic [34:0] mp;
  logic [32:0] wp;
  logic [31:0] bp;
  clock_t      clock4;
  days_t       days4;
  days_t       wx4;

  logic [4:0]  hr;
  logic [10:0] mt;
  logic [12:0] wq;
  logic [5:0]  blk;

  always_comb begin
    hr  = 5'(hp >> HOUR_SH);
    mt  = 11'(mp >> MIN_SH);
    wq  = 13'(wp >> WEEK_SH);
    blk = 6'(bp >> QUAD_SH);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hp     <= 34'(clock) * 34'(HOUR_RECIP);
      mp     <= 35'(clock) * 35'(MIN_RECIP);
      wp     <= 33'(days + days_t'(WEEKDAY_BIAS)) * 33'(WEEK_RECIP);
      bp     <= 32'(days) * 32'(QUAD_RECIP);
      clock4 <= clock;
      days4  <= days;
      wx4    <= days + days_t'(WEEKDAY_BIAS);
    end
    if (en[1]) begin
      tod.hour    <= hr;
      tod.minute  <= 6'(mt - 11'(hr) * 11'(MINS_PER_HOUR));
      tod.second  <= 6'(clock4 - 17'(mt) * 17'(SECS_PER_MIN));
      tod.weekday <= 3'(wx4 - days_t'(wq) * days_t'(DAYS_PER_WEEK));
      quad        <= blk;
      quad_day    <= 11'(days4 - days_t'(blk) * days_t'(QUAD_DAYS));
    end
  end

endmodule

[design/e2c_date.sv]
module e2c_date (
  input  logic          clk,
  input  logic [1:0]    en,
  input  e2c_pkg::tod_t tod,
  input  logic [5:0]    quad,
  input  logic [10:0]   quad_day,
  output e2c_pkg::tod_t tod_out,
  output logic [11:0]   year,
  output logic [3:0]    month,
  output logic [4:0]    day
);
  import e2c_pkg::*;

  logic [1:0]  y_in;
  logic [10:0] y_base;
  tod_t        tod6;
  logic [11:0] year6;
  logic [8:0]  doy6;
  logic        leap6;
  logic [3:0]  cnt;

  // four-year block starts at 1970: 365, 365, 366, 365
  always_comb begin
    if (quad_day < 11'd365) begin
      y_in = 2'd0; y_base = 11'd0;
    end else if (quad_day < 11'd730) begin
      y_in = 2'd1; y_base = 11'd365;
    end else if (quad_day < 11'd1096) begin
      y_in = 2'd2; y_base = 11'd730;
    end else begin
      y_in = 2'd3; y_base = 11'd1096;
    end
  end

  always_comb begin
    cnt = '0;
    for (int i = 1; i < 12; i++) begin
      cnt = cnt + 4'(doy6 >= month_start(leap6, 4'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tod6  <= tod;
      year6 <= 12'(BASE_YEAR) + 12'({quad, y_in});
      doy6  <= 9'(quad_day - y_base);
      leap6 <= (y_in == 2'd2);
    end
    if (en[1]) begin
      tod_out <= tod6;
      year    <= year6;
      month   <= cnt + 4'd1;
      day     <= 5'(doy6 - month_start(leap6, cnt) + 9'd1);
    end
  end

endmodule

[verif/epoch_to_calendar_core_tb.sv]
`timescale 1ns / 100ps

module epoch_to_calendar_core_tb;

  localparam int ZONE_STEP     = 900;
  localparam int DAY_SECS      = 86400;
  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 190;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } civil_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic signed [7:0] tz_offset_units = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [31:0]       epoch_seconds = '0;
  logic [7:0]        day_offset = '0;
  logic              kind = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [11:0]       year;
  logic [3:0]        month;
  logic [4:0]        day;
  logic [4:0]        hour;
  logic [5:0]        minute;
  logic [5:0]        second;
  logic [2:0]        weekday;

  civil_t            civil_expected[$];
  logic signed [7:0] zone_units = '0;
  int                mismatch_count = 0;
  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;
  int                hold_left = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  epoch_to_calendar_core #(
    .TZ_UNIT_SECONDS(ZONE_STEP)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .tz_offset_units (tz_offset_units),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .epoch_seconds   (epoch_seconds),
    .day_offset      (day_offset),
    .kind            (kind),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .year            (year),
    .month           (month),
    .day             (day),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .weekday         (weekday)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shift by whole days, add the zone, then split into date and time of day.
  function automatic civil_t epoch_to_civil(input logic [31:0] secs, input logic [7:0] days_in,
                                            input logic back, input logic signed [7:0] zone);
    logic [31:0] shift;
    logic [31:0] t;
    logic [31:0] days;
    logic [31:0] tod;
    int          zone_s;
    int unsigned yr;
    int unsigned mo;
    int unsigned ylen;
    int unsigned mlen[12];
    civil_t      r;
    shift  = 32'(days_in) * 32'(DAY_SECS);
    t      = back ? secs - shift : secs + shift;
    zone_s = int'(zone) * ZONE_STEP;
    t      = t + 32'(zone_s);
    days   = t / 32'(DAY_SECS);
    tod    = t - days * 32'(DAY_SECS);
    r.hour    = 5'(tod / 3600);
    r.minute  = 6'((tod % 3600) / 60);
    r.second  = 6'(tod % 60);
    r.weekday = 3'((days + 3) % 7);
    yr = 1970;
    for (int i = 0; i < 200; i++) begin
      ylen = (yr % 4 == 0) ? 366 : 365;
      if (days < ylen) break;
      days = days - ylen;
      yr++;
    end
    mlen = '{31, (yr % 4 == 0) ? 29 : 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    mo = 1;
    for (int i = 0; i < 12; i++) begin
      if (days < mlen[i]) break;
      days = days - mlen[i];
      mo++;
    end
    r.year  = 12'(yr);
    r.month = 4'(mo);
    r.day   = 5'(days + 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Output side: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    civil_t want;
    if (!rst && out_valid && !out_stall) begin
      if (civil_expected.size() == 0) begin
        report_mismatch("unexpected result", 32'(year), 32'hFFFF_FFFF);
      end else begin
        want = civil_expected.pop_front();
        check_field("year", 32'(year), 32'(want.year));
        check_field("month", 32'(month), 32'(want.month));
        check_field("day", 32'(day), 32'(want.day));
        check_field("hour", 32'(hour), 32'(want.hour));
        check_field("minute", 32'(minute), 32'(want.minute));
        check_field("second", 32'(second), 32'(want.second));
        check_field("weekday", 32'(weekday), 32'(want.weekday));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_timestamp(input logic [31:0] secs, input logic [7:0] days_in,
                                input logic back);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    day_offset    <= days_in;
    kind          <= back;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    civil_expected.push_back(epoch_to_civil(secs, days_in, back, zone_units));
  endtask

  task automatic stop_and_drain();
    in_valid <= 1'b0;
    while (civil_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_zone(input logic signed [7:0] value);
    cfg_valid       <= 1'b1;
    tz_offset_units <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    zone_units = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_timestamp();
    logic [31:0] secs;
    case ($urandom_range(0, 7))
      0: secs = $urandom_range(0, 3 * DAY_SECS);
      1: secs = 32'hFFFF_FFFF - $urandom_range(0, 3 * DAY_SECS);
      2: secs = 32'($urandom_range(0, 49710)) * 32'(DAY_SECS) - 32'($urandom_range(0, 2));
      default: secs = $urandom;
    endcase
    send_timestamp(secs, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed_utc();
    write_zone(8'sd0);
    send_timestamp(32'd0, 8'd0, 1'b0);
    send_timestamp(32'hFFFF_FFFF, 8'd0, 1'b0);
    send_timestamp(32'd0, 8'd1, 1'b1);             // wraps below zero
    send_timestamp(32'hFFFF_FFFF, 8'd255, 1'b0);   // wraps past the top
    send_timestamp(32'd86399, 8'd255, 1'b0);
    send_timestamp(32'd94694399, 8'd0, 1'b0);      // last second of a leap year
    send_timestamp(32'd951782400, 8'd0, 1'b0);     // 29 February 2000
    send_timestamp(32'd4107542400, 8'd1, 1'b1);    // 28 February 2100, a year the core takes as leap
    send_timestamp(32'd1709251199, 8'd200, 1'b1);
    stop_and_drain();
  endtask

  task automatic test_zone_extremes();
    write_zone(8'sd127);
    send_timestamp(32'd0, 8'd0, 1'b0);
    send_timestamp(32'hFFFF_FFFF, 8'd0, 1'b0);
    send_timestamp(32'd951868799, 8'd3, 1'b1);
    send_timestamp(32'h8000_0000, 8'd128, 1'b0);
    stop_and_drain();
    write_zone(-8'sd128);
    send_timestamp(32'd0, 8'd0, 1'b0);
    send_timestamp(32'hFFFF_FFFF, 8'd255, 1'b1);
    send_timestamp(32'd115200, 8'd0, 1'b0);
    send_timestamp(32'h7FFF_FFFF, 8'd127, 1'b1);
    stop_and_drain();
    write_zone(8'sd96);
    send_timestamp(32'hFFFF_FFFF - 32'd86400, 8'd0, 1'b0);
    send_timestamp(32'd68169599, 8'd0, 1'b0);
    stop_and_drain();
    write_zone(-8'sd96);
    send_timestamp(32'd1000, 8'd0, 1'b0);
    send_timestamp(32'd5184000, 8'd60, 1'b1);
    stop_and_drain();
  endtask

  task automatic test_random_zones();
    logic signed [7:0] z;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: z = -8'sd128;
        1: z = 8'sd127;
        default: z = 8'($urandom);
      endcase
      write_zone(z);
      repeat (PHASE_ITEMS) send_random_timestamp();
      stop_and_drain();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the pipe fills.
  task automatic test_backpressure();
    write_zone(8'($urandom));
    hold_req = 1'b1;
    repeat (40) send_random_timestamp();
    stop_and_drain();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    write_zone(8'($urandom_range(0, 96)));
    repeat (100) send_random_timestamp();
    stop_and_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_utc();
    test_zone_extremes();
    test_random_zones();
    test_backpressure();
    test_steady_stream();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && civil_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[epoch_to_calendar_core.f]
+incdir+design
design/e2c_pkg.sv
design/e2c_front.sv
design/e2c_split.sv
design/e2c_date.sv
design/epoch_to_calendar_core.sv
verif/epoch_to_calendar_core_tb.sv
